// File: design/tsps_pkg.sv
// Shared constants for the time slice priority scheduler.
package tsps_pkg;

  localparam int unsigned TASK_COUNT_DEF = 16;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned TASK_W  = 4;
  localparam int unsigned COUNT_W = 4;

  localparam logic [CMD_W-1:0] CMD_TICK     = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SET_PRIO = 1'b1;

  // Priority of a task that has never been written.
  localparam logic [COUNT_W-1:0] PRIO_RESET = COUNT_W'(1);

endpackage

// File: design/time_slice_priority_scheduler.sv
// A tick that leaves the running task with time left, and a priority write, give their word
// in the cycle after start. A tick that reschedules gives its word after a scan of the table,
// or after a scan and a refill pass when the counters are refilled.
// Throughput: one command at a time; busy stays high for the whole scan and refill.
// Reset (rst_ni low, asynchronous): idle task running, all counters zero, all priorities one.
// The receiver cannot stall: res_valid_o is high for exactly one cycle per command.
module time_slice_priority_scheduler #(
  parameter int unsigned TASK_COUNT = tsps_pkg::TASK_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [tsps_pkg::CMD_W-1:0]     cmd_i,
  input  logic [tsps_pkg::TASK_W-1:0]    task_index_i,
  input  logic [tsps_pkg::COUNT_W-1:0]   priority_value_i,
  output logic                           res_valid_o,
  output logic [tsps_pkg::TASK_W-1:0]    running_task_o,
  output logic                           switched_o,
  output logic                           refilled_o,
  output logic [tsps_pkg::COUNT_W-1:0]   slice_left_o
);

  localparam int unsigned IDX_W = $clog2(TASK_COUNT);
  localparam int unsigned CW    = tsps_pkg::COUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TASK_COUNT - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_REFILL = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;          // next table entry to read
  logic             issue_q, issue_d;      // a read is issued this cycle
  logic             rd_en_q;               // read data is valid this cycle
  logic [IDX_W-1:0] rd_idx_q;              // entry that the read data belongs to
  logic             rd_cvld_q, rd_pvld_q;  // entry had been written when read
  logic [IDX_W-1:0] best_idx_q;
  logic [CW-1:0]    best_val_q;
  logic [IDX_W-1:0] run_q, run_d;          // running task
  logic [CW-1:0]    run_cnt_q, run_cnt_d;  // its remaining slice, mirrors the table

  logic [TASK_COUNT-1:0] cnt_vld_q, prio_vld_q;

  // Result word.
  logic             res_valid_q, res_valid_d;
  logic [IDX_W-1:0] res_task_q, res_task_d;
  logic             res_sw_q, res_sw_d;
  logic             res_rf_q, res_rf_d;
  logic [CW-1:0]    res_slice_q, res_slice_d;

  logic             accept;
  logic             prio_we;
  logic [IDX_W-1:0] set_addr;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic [CW-1:0]    cnt_rdata, prio_rdata;
  logic [CW-1:0]    cval, pval, cand_val;
  logic [IDX_W-1:0] nxt_idx;
  logic [CW-1:0]    nxt_val;
  logic             scan_last;
  logic [CW-1:0]    dec_cnt;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign set_addr = IDX_W'(task_index_i);

  // Drop writes to the idle task and to indexes past the table.
  assign prio_we = accept && (cmd_i == tsps_pkg::CMD_SET_PRIO)
                   && (task_index_i != '0)
                   && (32'(task_index_i) < 32'(TASK_COUNT));

  tsps_ram #(
    .WIDTH (CW),
    .DEPTH (TASK_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (ptr_q),
    .rdata_o (cnt_rdata)
  );

  tsps_ram #(
    .WIDTH (CW),
    .DEPTH (TASK_COUNT)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (set_addr),
    .wdata_i (priority_value_i),
    .raddr_i (ptr_q),
    .rdata_o (prio_rdata)
  );

  // Unwritten entries read as their reset values.
  assign cval     = rd_cvld_q ? cnt_rdata : '0;
  assign pval     = rd_pvld_q ? prio_rdata : tsps_pkg::PRIO_RESET;
  // The refill pass writes the priorities and picks from them in the same sweep,
  // which is exactly the rescan over the reloaded counters.
  assign cand_val = (state_q == ST_REFILL) ? pval : cval;

  tsps_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .en_i       (rd_en_q),
    .cand_idx_i (rd_idx_q),
    .cand_val_i (cand_val),
    .best_idx_i (best_idx_q),
    .best_val_i (best_val_q),
    .best_idx_o (nxt_idx),
    .best_val_o (nxt_val)
  );

  assign scan_last = rd_en_q && (rd_idx_q == LAST_IDX);
  assign dec_cnt   = run_cnt_q - CW'(1);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    issue_d     = 1'b0;
    run_d       = run_q;
    run_cnt_d   = run_cnt_q;
    res_valid_d = 1'b0;
    res_task_d  = res_task_q;
    res_sw_d    = res_sw_q;
    res_rf_d    = res_rf_q;
    res_slice_d = res_slice_q;
    cnt_we      = 1'b0;
    cnt_waddr   = run_q;
    cnt_wdata   = dec_cnt;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == tsps_pkg::CMD_SET_PRIO) begin
            res_valid_d = 1'b1;
            res_task_d  = run_q;
            res_sw_d    = 1'b0;
            res_rf_d    = 1'b0;
            res_slice_d = run_cnt_q;
          end else if (run_cnt_q > CW'(1)) begin
            // Still time left after the decrement: keep the task.
            cnt_we      = 1'b1;
            run_cnt_d   = dec_cnt;
            res_valid_d = 1'b1;
            res_task_d  = run_q;
            res_sw_d    = 1'b0;
            res_rf_d    = 1'b0;
            res_slice_d = dec_cnt;
          end else begin
            cnt_we    = (run_cnt_q != '0);
            run_cnt_d = '0;
            state_d   = ST_SCAN;
            ptr_d     = FIRST_IDX;
            issue_d   = 1'b1;
          end
        end
      end

      ST_SCAN, ST_REFILL: begin
        if (issue_q) begin
          ptr_d   = ptr_q + IDX_W'(1);
          issue_d = (ptr_q != LAST_IDX);
        end
        if (state_q == ST_REFILL) begin
          cnt_we    = rd_en_q;
          cnt_waddr = rd_idx_q;
          cnt_wdata = pval;
        end
        if (scan_last) begin
          if ((state_q == ST_SCAN) && (nxt_val == '0)) begin
            // Every counter is empty: reload and pick again.
            state_d = ST_REFILL;
            ptr_d   = FIRST_IDX;
            issue_d = 1'b1;
          end else begin
            state_d     = ST_IDLE;
            res_valid_d = 1'b1;
            res_rf_d    = (state_q == ST_REFILL);
            // With all priorities zero the running task stays, and its count is zero.
            if (nxt_val != '0) begin
              run_d = nxt_idx;
            end
            run_cnt_d   = nxt_val;
            res_task_d  = (nxt_val != '0) ? nxt_idx : run_q;
            res_sw_d    = (nxt_val != '0) && (nxt_idx != run_q);
            res_slice_d = nxt_val;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= FIRST_IDX;
      issue_q     <= 1'b0;
      rd_en_q     <= 1'b0;
      run_q       <= '0;
      run_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      cnt_vld_q   <= '0;
      prio_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      issue_q     <= issue_d;
      rd_en_q     <= issue_q;
      run_q       <= run_d;
      run_cnt_q   <= run_cnt_d;
      res_valid_q <= res_valid_d;
      if (cnt_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
      if (prio_we) begin
        prio_vld_q[set_addr] <= 1'b1;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= ptr_q;
    rd_cvld_q   <= cnt_vld_q[ptr_q];
    rd_pvld_q   <= prio_vld_q[ptr_q];
    res_task_q  <= res_task_d;
    res_sw_q    <= res_sw_d;
    res_rf_q    <= res_rf_d;
    res_slice_q <= res_slice_d;
    if (state_d == ST_IDLE || state_d != state_q) begin
      best_idx_q <= '0;
      best_val_q <= '0;
    end else begin
      best_idx_q <= nxt_idx;
      best_val_q <= nxt_val;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign running_task_o = tsps_pkg::TASK_W'(res_task_q);
  assign switched_o     = res_sw_q;
  assign refilled_o     = res_rf_q;
  assign slice_left_o   = res_slice_q;

  // A priority write answers on the next cycle with neither flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == tsps_pkg::CMD_SET_PRIO)) |=> (res_valid_o && !switched_o && !refilled_o))
    else $error("priority write did not answer in one cycle");

  // A result word only leaves once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (state_q == ST_IDLE))
    else $error("result word while sequencer busy");

  // A switch flag means the running task really changed on that edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && switched_o) |-> (run_q != $past(run_q)))
    else $error("switch reported without a task change");

  // The running count mirrors the word reported last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (slice_left_o == run_cnt_q))
    else $error("reported slice differs from running count");

endmodule

// File: design/tsps_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tsps_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/tsps_pick.sv
// Compare and select unit: keeps the largest slice count seen, first index wins.
module tsps_pick #(
  parameter int unsigned IDX_W = 4
) (
  input  logic                           en_i,
  input  logic [IDX_W-1:0]               cand_idx_i,
  input  logic [tsps_pkg::COUNT_W-1:0]   cand_val_i,
  input  logic [IDX_W-1:0]               best_idx_i,
  input  logic [tsps_pkg::COUNT_W-1:0]   best_val_i,
  output logic [IDX_W-1:0]               best_idx_o,
  output logic [tsps_pkg::COUNT_W-1:0]   best_val_o
);

  logic take;

  // Strictly greater, so an equal count later in the scan never wins.
  assign take       = en_i && (cand_val_i > best_val_i);
  assign best_idx_o = take ? cand_idx_i : best_idx_i;
  assign best_val_o = take ? cand_val_i : best_val_i;

endmodule

// File: bench/time_slice_priority_scheduler_tb.sv
// Self-checking testbench for the time slice priority scheduler.
module time_slice_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsps_pkg::*;

  localparam int unsigned TASKS      = TASK_COUNT_DEF;
  localparam int unsigned WORD_GOAL  = 1050;
  localparam int unsigned STALL_MAX  = 1000;  // cycles with no handshake before giving up
  localparam int unsigned PRINT_MAX  = 40;    // mismatch lines printed before going quiet
  localparam int unsigned DIR_N      = 25;

  // One scheduler result word.
  typedef struct packed {
    logic [TASK_W-1:0]  running_task;
    logic               switched;
    logic               refilled;
    logic [COUNT_W-1:0] slice_left;
  } sched_word_t;

  // One row of the directed sequence; typed rows carry their result inline.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TASK_W-1:0]  idx;
    logic [COUNT_W-1:0] prio;
    logic               typed;
    sched_word_t        want;
  } dir_row_t;

  localparam sched_word_t NO_WORD = '0;

  // Open with the idle task running: the first tick finds every counter empty,
  // refills from the reset priorities and lands on task 1. Then walk ignored
  // writes (index zero), extreme priorities, a write to the running task, and
  // drain the table until a refill picks the lowest of several tied tasks.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{CMD_TICK,     4'd0,  4'd0,  1'b1, '{4'd1, 1'b1, 1'b1, 4'd1}},
    '{CMD_TICK,     4'd15, 4'd15, 1'b1, '{4'd2, 1'b1, 1'b0, 4'd1}},
    '{CMD_SET_PRIO, 4'd0,  4'd15, 1'b1, '{4'd2, 1'b0, 1'b0, 4'd1}},
    '{CMD_SET_PRIO, 4'd15, 4'd15, 1'b1, '{4'd2, 1'b0, 1'b0, 4'd1}},
    '{CMD_SET_PRIO, 4'd1,  4'd0,  1'b1, '{4'd2, 1'b0, 1'b0, 4'd1}},
    '{CMD_SET_PRIO, 4'd2,  4'd15, 1'b1, '{4'd2, 1'b0, 1'b0, 4'd1}},
    '{CMD_TICK,     4'd0,  4'd0,  1'b1, '{4'd3, 1'b1, 1'b0, 4'd1}},
    '{CMD_SET_PRIO, 4'd7,  4'd8,  1'b0, NO_WORD},
    '{CMD_SET_PRIO, 4'd14, 4'd0,  1'b0, NO_WORD},
    '{CMD_SET_PRIO, 4'd9,  4'd7,  1'b0, NO_WORD},
    '{CMD_SET_PRIO, 4'd4,  4'd15, 1'b0, NO_WORD},
    '{CMD_SET_PRIO, 4'd10, 4'd10, 1'b0, NO_WORD},
    '{CMD_TICK,     4'd5,  4'd5,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd10, 4'd10, 1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd15, 4'd15, 1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD},
    '{CMD_TICK,     4'd0,  4'd0,  1'b0, NO_WORD}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd_i;
  logic [TASK_W-1:0]   task_index_i;
  logic [COUNT_W-1:0]  priority_value_i;
  logic                res_valid_o;
  logic [TASK_W-1:0]   running_task_o;
  logic                switched_o;
  logic                refilled_o;
  logic [COUNT_W-1:0]  slice_left_o;

  time_slice_priority_scheduler #(
    .TASK_COUNT(TASKS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .task_index_i     (task_index_i),
    .priority_value_i (priority_value_i),
    .res_valid_o      (res_valid_o),
    .running_task_o   (running_task_o),
    .switched_o       (switched_o),
    .refilled_o       (refilled_o),
    .slice_left_o     (slice_left_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Shadow scheduler state.
  logic [COUNT_W-1:0] slice_tbl [TASKS];
  logic [COUNT_W-1:0] prio_tbl  [TASKS];
  logic [TASK_W-1:0]  cur_task;

  sched_word_t pending_sched[$];   // results still owed by the block

  int unsigned words_in;      // input words taken by the block
  int unsigned words_sent;    // words that do something (writes to task 0 excluded)
  int unsigned words_checked;
  int unsigned refills_seen;
  int unsigned switches_seen;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned idle_pct;

  // Print one mismatch line and count it; go quiet after a while.
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_MAX)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Highest counter among tasks 1..TASKS-1, lowest index on a tie; 0 when all are empty.
  function automatic logic [TASK_W-1:0] longest_slice();
    logic [TASK_W-1:0]  best;
    logic [COUNT_W-1:0] best_cnt;
    best     = '0;
    best_cnt = '0;
    for (int i = 1; i < TASKS; i++) begin
      if (slice_tbl[i] > best_cnt) begin
        best_cnt = slice_tbl[i];
        best     = TASK_W'(i);
      end
    end
    return best;
  endfunction

  // Advance the shadow state by one word and return the result it must produce.
  function automatic sched_word_t next_schedule(input logic [CMD_W-1:0] c,
                                                input logic [TASK_W-1:0] ti,
                                                input logic [COUNT_W-1:0] pv);
    sched_word_t       w;
    logic [TASK_W-1:0] prev;
    logic [TASK_W-1:0] nxt;
    logic              resched;
    logic              did_refill;
    prev       = cur_task;
    did_refill = 1'b0;
    if (c == CMD_SET_PRIO) begin
      // Task 0 keeps its priority; the counter of the written task is untouched.
      if (ti != '0 && int'(ti) < TASKS)
        prio_tbl[ti] = pv;
    end else begin
      resched = 1'b1;
      if (slice_tbl[cur_task] != '0) begin
        slice_tbl[cur_task] = slice_tbl[cur_task] - 1'b1;
        if (slice_tbl[cur_task] != '0)
          resched = 1'b0;
      end
      if (resched) begin
        nxt = longest_slice();
        if (nxt == '0) begin
          // Every counter empty: reload from the priorities and scan again.
          for (int i = 1; i < TASKS; i++)
            slice_tbl[i] = prio_tbl[i];
          did_refill = 1'b1;
          nxt = longest_slice();
        end
        // With every priority at zero nothing can be picked; keep the current task.
        if (nxt != '0)
          cur_task = nxt;
      end
    end
    w.running_task = cur_task;
    w.switched     = (cur_task != prev);
    w.refilled     = did_refill;
    w.slice_left   = slice_tbl[cur_task];
    return w;
  endfunction

  // Offer one word, optionally after a gap, and hold it until the block takes it.
  // The expectation is queued at the falling edge after the handshake, which is
  // always before the earliest possible result strobe.
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [TASK_W-1:0] ti,
                           input logic [COUNT_W-1:0] pv, input logic typed,
                           input sched_word_t want);
    int unsigned target;
    sched_word_t w;
    // Idle the sender cycle by cycle at the current rate.
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start            <= 1'b1;
    cmd_i            <= c;
    task_index_i     <= ti;
    priority_value_i <= pv;
    target = words_in + 1;
    do @(negedge clk_i); while (words_in < target);
    w = next_schedule(c, ti, pv);
    pending_sched.push_back(typed ? want : w);
    if (!(c == CMD_SET_PRIO && ti == '0))
      words_sent++;
  endtask

  // Pick the sender's idle rate from how far the run has come.
  function automatic int unsigned phase_idle();
    if (words_sent < WORD_GOAL / 3)
      return 26;
    else if (words_sent < 2 * WORD_GOAL / 3)
      return 76;
    return 0;
  endfunction

  // Check results, count handshakes and watch for a hang.
  always @(posedge clk_i) begin
    sched_word_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (pending_sched.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: task %0d", running_task_o));
        end else begin
          want = pending_sched.pop_front();
          words_checked++;
          if (running_task_o !== want.running_task)
            report_mismatch($sformatf("running_task got %0d want %0d",
                                      running_task_o, want.running_task));
          if (switched_o !== want.switched)
            report_mismatch($sformatf("switched got %b want %b", switched_o, want.switched));
          if (refilled_o !== want.refilled)
            report_mismatch($sformatf("refilled got %b want %b", refilled_o, want.refilled));
          if (slice_left_o !== want.slice_left)
            report_mismatch($sformatf("slice_left got %0d want %0d",
                                      slice_left_o, want.slice_left));
          if (want.refilled)
            refills_seen++;
          if (want.switched)
            switches_seen++;
        end
      end
      if (start && !busy)
        words_in++;
      if (res_valid_o || (start && !busy))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("[%0t] timeout: no handshake for %0d cycles", $realtime, STALL_MAX);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    logic [COUNT_W-1:0] pv;

    // Drive every input to a known value before the first edge.
    rst_ni           = 1'b0;
    start            = 1'b0;
    cmd_i            = CMD_TICK;
    task_index_i     = '0;
    priority_value_i = '0;
    words_in         = 0;
    words_sent       = 0;
    words_checked    = 0;
    refills_seen     = 0;
    switches_seen    = 0;
    fail_count       = 0;
    quiet_cycles     = 0;
    idle_pct         = 0;

    // Shadow state after reset: idle task running, counters empty, priorities one.
    for (int i = 0; i < TASKS; i++) begin
      slice_tbl[i] = '0;
      prio_tbl[i]  = PRIO_RESET;
    end
    cur_task = '0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    for (int r = 0; r < DIR_N; r++) begin
      idle_pct = phase_idle();
      send_word(DIR_ROWS[r].cmd, DIR_ROWS[r].idx, DIR_ROWS[r].prio,
                DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    // Random part: mostly runs of ticks that exercise draining and refills,
    // mixed with priority updates, starvation runs and plain noise.
    while (words_sent < WORD_GOAL) begin
      idle_pct = phase_idle();
      pick = $urandom_range(99);
      if (pick < 55) begin
        n = $urandom_range(1, 16);
        repeat (n)
          send_word(CMD_TICK, TASK_W'($urandom), COUNT_W'($urandom), 1'b0, NO_WORD);
      end else if (pick < 80) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          pv = ($urandom_range(7) == 0) ? {COUNT_W{$urandom_range(1) == 1}}
                                        : COUNT_W'($urandom);
          send_word(CMD_SET_PRIO, TASK_W'($urandom), pv, 1'b0, NO_WORD);
        end
      end else if (pick < 90) begin
        // Zero every priority, tick so that any refill in the run
        // finds nothing, then restore random priorities.
        for (int t = 1; t < TASKS; t++)
          send_word(CMD_SET_PRIO, TASK_W'(t), '0, 1'b0, NO_WORD);
        n = $urandom_range(TASKS, 2 * TASKS);
        repeat (n)
          send_word(CMD_TICK, TASK_W'($urandom), COUNT_W'($urandom), 1'b0, NO_WORD);
        for (int t = 1; t < TASKS; t++)
          send_word(CMD_SET_PRIO, TASK_W'(t), COUNT_W'($urandom), 1'b0, NO_WORD);
      end else begin
        send_word(CMD_W'($urandom), TASK_W'($urandom), COUNT_W'($urandom), 1'b0, NO_WORD);
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then give any stray strobe time to show up.
    while (pending_sched.size() != 0)
      @(posedge clk_i);
    repeat (2 * TASKS + 4) @(posedge clk_i);

    $display("Covered %0d words (%0d results checked), %0d task switches, %0d refills.",
             words_sent, words_checked, switches_seen, refills_seen);
    $display("Mismatches: %0d", fail_count);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
design/tsps_pkg.sv
design/tsps_ram.sv
design/tsps_pick.sv
design/time_slice_priority_scheduler.sv
bench/time_slice_priority_scheduler_tb.sv
